/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising edge of clk outside reset.
`define GPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that expr never holds at a rising edge of clk outside reset.
`define GPC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define GPC_ASSERT(lbl, clk, rstn, prop, msg)
`define GPC_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* hdl/gpc_pkg.sv */
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared widths, constants and window matching for the 3x3 pattern counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 20;

    localparam int CELL_W      = 8;
    localparam int ROW_WIDTH_W = 11;
    localparam int COUNT_OUT_W = 20;
    localparam int OUT_TDATA_W = 24;
    localparam int LINE_W      = 2;   // bit 0: row r-2 mark, bit 1: row r-1 mark
    localparam int WIN_W       = 9;

    localparam logic [CELL_W-1:0]      MARK_CHAR       = 8'd42;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // Rows seen in the frame, saturating once a full window height exists
    localparam logic [1:0] ROW_CNT_FULL = 2'd2;

    // Six-cell shapes; bit r*3+k is window row r, column k (k = 0 leftmost)
    localparam logic [WIN_W-1:0] SHAPE_MASKS [8] = '{
        9'h12F, 9'h1E6, 9'h1E9, 9'h0CF, 9'h06F, 9'h1A7, 9'h1EC, 9'h1CB
    };

    function automatic logic [WIN_W-1:0] build_window(
        input logic [2:0] left,
        input logic [2:0] mid,
        input logic [2:0] right
    );
        logic [WIN_W-1:0] win;
        win = '0;
        for (int r = 0; r < 3; r++) begin
            win[r*3 + 0] = left[r];
            win[r*3 + 1] = mid[r];
            win[r*3 + 2] = right[r];
        end
        return win;
    endfunction

    function automatic logic window_match(input logic [WIN_W-1:0] win);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < 8; s++) begin
            if ((win & SHAPE_MASKS[s]) == SHAPE_MASKS[s]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* hdl/gpc_line_ram.sv */
// ----------------------------------------------------------------------------
// gpc_line_ram
// Simple dual-port line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpc_line_ram #(
    parameter  int DEPTH  = gpc_pkg::MAX_WIDTH_DEF,
    parameter  int DATA_W = gpc_pkg::LINE_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/grid_3x3_pattern_counter.sv */
// ----------------------------------------------------------------------------
// grid_3x3_pattern_counter
// Counts 3x3 windows of a raster character grid that match any of eight
// six-cell shapes; reports the saturating count at the end of each grid.
// ----------------------------------------------------------------------------
// Cells stream in raster order, one byte per word, and the block takes one
// cell every clock cycle while tready is high. A cell is marked when it is
// '*'. The marks of the two rows above live in one line RAM, 2 bits by
// MAX_WIDTH, read at the accept edge and written back in the cycle after;
// a one-entry forward covers back-to-back cells on the same column (row
// width of one). The word with tlast set closes the grid: its own window is
// counted, and its count goes from the update stage into a two-word output
// queue, so the input keeps flowing while one result waits; tready drops
// only while two results are waiting or in flight. The line RAM needs no
// clearing pass after reset or after a grid: a high-water mark of the
// columns written in the current grid makes unwritten entries read as zero.
// row_width is taken from cfg_wr_data whenever cfg_wr_en is high; zero acts
// as one, and values above MAX_WIDTH act as MAX_WIDTH.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_3x3_pattern_counter #(
    parameter int MAX_WIDTH  = gpc_pkg::MAX_WIDTH_DEF,
    parameter int COUNT_BITS = gpc_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [gpc_pkg::ROW_WIDTH_W-1:0]  cfg_wr_data,   // row_width
    // cell stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gpc_pkg::CELL_W-1:0]       s_tdata,       // [7:0] cell_char
    input  logic                             s_tlast,       // frame_last
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gpc_pkg::OUT_TDATA_W-1:0]  m_tdata,       // [19:0] window_count
    output logic                             m_tuser        // [0] count_saturated
);

    import gpc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);       // column index bits
    localparam int FW = CW + 1;                  // high-water mark, 0..MAX_WIDTH
    localparam int EW = (FW > ROW_WIDTH_W) ? FW : ROW_WIDTH_W;
    localparam logic [EW-1:0]         MAX_W_E   = EW'(MAX_WIDTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                   sat;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

    // ---------------------------------------------------------------- config
    logic [ROW_WIDTH_W-1:0] row_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    // Effective width: clamp to 1..MAX_WIDTH
    logic [EW-1:0] rw_e;
    logic [EW-1:0] eff_w;

    always_comb begin
        rw_e = EW'(row_width_reg);
        if (rw_e == '0) begin
            eff_w = EW'(1);
        end else if (rw_e > MAX_W_E) begin
            eff_w = MAX_W_E;
        end else begin
            eff_w = rw_e;
        end
    end

    // ------------------------------------------------------- accept stage
    logic          acc;
    logic [CW-1:0] col_reg,  col_next;
    logic [1:0]    row_reg,  row_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [EW-1:0] col_inc;
    logic [FW-1:0] col_inc_f;
    logic          col_wrap;
    logic          rd_hit;
    logic          win_full;

    assign acc = s_tvalid && s_tready;

    always_comb begin
        col_inc   = EW'(col_reg) + EW'(1);
        col_inc_f = FW'(col_reg) + FW'(1);
        col_wrap  = (col_inc >= eff_w);
        // entries past the high-water mark were not written in this grid
        rd_hit    = (FW'(col_reg) < fill_reg);
        win_full  = (row_reg == ROW_CNT_FULL) && (col_reg >= CW'(2));

        col_next  = col_reg;
        row_next  = row_reg;
        fill_next = fill_reg;
        if (acc) begin
            if (s_tlast) begin
                // drop the grid: the mark empties the line store at once
                col_next  = '0;
                row_next  = '0;
                fill_next = '0;
            end else begin
                col_next  = col_wrap ? '0 : CW'(col_inc);
                if (col_wrap && (row_reg != ROW_CNT_FULL)) begin
                    row_next = row_reg + 2'd1;
                end
                if (col_inc_f > fill_reg) begin
                    fill_next = col_inc_f;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            fill_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------- line store
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] ram_wr_data;
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s1_mark_reg;
    logic              s1_hit_reg;
    logic              s1_full_reg;
    logic [CW-1:0]     s1_col_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    gpc_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr_data),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // Advance the accepted cell into the update stage; capture the write that
    // lands on the same edge as the read so it can be forwarded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_last_reg <= s_tlast;
            s1_mark_reg <= (s_tdata == MARK_CHAR);
            s1_hit_reg  <= rd_hit;
            s1_full_reg <= win_full;
            s1_col_reg  <= col_reg;
        end
        fwd_data_reg <= ram_wr_data;
    end

    // ------------------------------------------------------- update stage
    logic [LINE_W-1:0]     line_rd;
    logic [2:0]            triple;
    logic [5:0]            win_cols_reg;
    logic [WIN_W-1:0]      win;
    logic                  win_match;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_new;
    result_t               res;
    logic                  s1_push;

    always_comb begin
        if (!s1_hit_reg) begin
            line_rd = '0;
        end else if (fwd_hit_reg) begin
            line_rd = fwd_data_reg;
        end else begin
            line_rd = ram_rd_data;
        end
        // column of the current cell: bit 0 row r-2, bit 1 row r-1, bit 2 row r
        triple      = {s1_mark_reg, line_rd[1], line_rd[0]};
        // shift the column up: middle moves to upper, current to middle
        ram_wr_data = {s1_mark_reg, line_rd[1]};
        win         = build_window(win_cols_reg[2:0], win_cols_reg[5:3], triple);
        win_match   = s1_full_reg && window_match(win);
        count_new   = count_reg;
        if (win_match && (count_reg != COUNT_MAX)) begin
            count_new = count_reg + COUNT_BITS'(1);
        end
        res.count = COUNT_OUT_W'(count_new);
        res.sat   = (count_new == COUNT_MAX);
        s1_push   = s1_valid_reg && s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cols_reg <= '0;
            count_reg    <= '0;
        end else if (s1_valid_reg) begin
            if (s1_last_reg) begin
                win_cols_reg <= '0;
                count_reg    <= '0;
            end else begin
                win_cols_reg <= {triple, win_cols_reg[5:3]};
                count_reg    <= count_new;
            end
        end
    end

    // ------------------------------------------------------- output queue
    result_t    q_data_reg [2];
    logic       q_wr_ptr_reg;
    logic       q_rd_ptr_reg;
    logic [1:0] q_count_reg;
    logic [1:0] q_count_next;
    logic       m_pop;
    result_t    q_head;

    assign m_pop = m_tvalid && m_tready;

    always_comb begin
        q_count_next = q_count_reg;
        if (s1_push && !m_pop) begin
            q_count_next = q_count_reg + 2'd1;
        end else if (!s1_push && m_pop) begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= '0;
        end else begin
            if (s1_push) begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (m_pop) begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_push) begin
            q_data_reg[q_wr_ptr_reg] <= res;
        end
    end

    // Hold off input while two results are queued or in flight
    assign s_tready = ((q_count_reg + 2'(s1_push)) < 2'd2);

    assign q_head   = q_data_reg[q_rd_ptr_reg];
    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = OUT_TDATA_W'(q_head.count);
    assign m_tuser  = q_head.sat;

    // ------------------------------------------------------- assertions
    `GPC_NEVER(a_queue_overflow, aclk, aresetn, s1_push && !m_pop && (q_count_reg == 2'd2), "result queue overflow")
    `GPC_ASSERT(a_forward_same_col, aclk, aresetn, (s1_valid_reg && $past(s1_valid_reg) && (s1_col_reg == $past(s1_col_reg))) |-> fwd_hit_reg, "missed forward on same column")
    `GPC_ASSERT(a_last_clears, aclk, aresetn, (acc && s_tlast) |=> ((col_reg == '0) && (fill_reg == '0) && (row_reg == '0)), "grid state not cleared after last word")
    `GPC_ASSERT(a_fill_bound, aclk, aresetn, (fill_reg <= FW'(MAX_WIDTH)) && (FW'(col_reg) <= fill_reg), "high-water mark out of range")

endmodule

/* dv/tb_grid_3x3_pattern_counter.sv */
// ----------------------------------------------------------------------------
// tb_grid_3x3_pattern_counter
// Self-checking bench for the 3x3 pattern counter. It streams character grids
// through the cell port under random sender gaps and receiver stalls. It
// reprograms row_width between grids and in the middle of a grid. Every
// returned count is compared with an in-bench model of the window search.
// ----------------------------------------------------------------------------
module tb_grid_3x3_pattern_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import gpc_pkg::*;

    localparam int          MAX_W       = MAX_WIDTH_DEF;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
    localparam int unsigned ROW_TOP     = 1023;
    localparam int          SETTLE      = 8;     // cycles for the line RAM and result path
    localparam int          ITEM_TARGET = 750;
    localparam int          GRID_TARGET = 45;
    localparam int          CALM_AFTER  = 650;

    localparam logic [CELL_W-1:0] DOT_CHAR = 8'h2E;

    // Six-cell shapes: bit r*3+k is window row r, column k (k = 0 leftmost)
    localparam logic [8:0] SHAPE_SET [8] = '{
        9'h12F, 9'h1E6, 9'h1E9, 9'h0CF, 9'h06F, 9'h1A7, 9'h1EC, 9'h1CB
    };

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   saturated;
    } grid_result_t;

    // ------------------------------------------------------------------------
    // Window tally: tracks the line stores, the window columns and the count,
    // and queues one expected result per closed grid.
    // ------------------------------------------------------------------------
    class grid_tally;
        bit                   upper_marks [MAX_W];
        bit                   middle_marks [MAX_W];
        bit [5:0]             prev_cols;
        int unsigned          col_idx;
        int unsigned          row_idx;
        int unsigned          tally;
        logic [ROW_WIDTH_W-1:0] width_reg;
        grid_result_t         expected_counts [$];
        int unsigned          fails;

        function new();
            width_reg = ROW_WIDTH_RESET;
            fails     = 0;
            clear_grid();
        endfunction

        function void clear_grid();
            foreach (upper_marks[i]) begin
                upper_marks[i]  = 1'b0;
                middle_marks[i] = 1'b0;
            end
            prev_cols = '0;
            col_idx   = 0;
            row_idx   = 0;
            tally     = 0;
        endfunction

        function void set_width(logic [ROW_WIDTH_W-1:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void note_cell(logic [CELL_W-1:0] ch, logic fin);
            bit           cur;
            bit           hit;
            int unsigned  w;
            int unsigned  col;
            bit [2:0]     triple;
            bit [8:0]     win;
            grid_result_t res;
            cur = (ch == MARK_CHAR);
            w   = width_reg;
            if (w == 0) begin
                w = 1;
            end
            if (w > MAX_W) begin
                w = MAX_W;
            end
            col    = col_idx % MAX_W;
            triple = {cur, middle_marks[col], upper_marks[col]};
            upper_marks[col]  = middle_marks[col];
            middle_marks[col] = cur;
            if (row_idx >= 2 && col >= 2) begin
                for (int r = 0; r < 3; r++) begin
                    win[r*3 + 0] = prev_cols[r];
                    win[r*3 + 1] = prev_cols[3 + r];
                    win[r*3 + 2] = triple[r];
                end
                hit = 1'b0;
                foreach (SHAPE_SET[s]) begin
                    if ((win & SHAPE_SET[s]) == SHAPE_SET[s]) begin
                        hit = 1'b1;
                    end
                end
                if (hit && tally < COUNT_MAX) begin
                    tally++;
                end
            end
            prev_cols = {triple, prev_cols[5:3]};
            if (col + 1 >= w) begin
                col_idx = 0;
                if (row_idx < ROW_TOP) begin
                    row_idx++;
                end
            end else begin
                col_idx = col + 1;
            end
            if (fin) begin
                res.count     = tally[COUNT_OUT_W-1:0];
                res.saturated = (tally == COUNT_MAX);
                expected_counts.push_back(res);
                clear_grid();
            end
        endfunction

        function void check_result(logic [COUNT_OUT_W-1:0] count, logic saturated);
            grid_result_t exp_res;
            if (expected_counts.size() == 0) begin
                $error("result word with no grid closed: window_count %0d", count);
                fails++;
                return;
            end
            exp_res = expected_counts.pop_front();
            if (count !== exp_res.count) begin
                $error("window_count: expected %0d, got %0d", exp_res.count, count);
                fails++;
            end
            if (saturated !== exp_res.saturated) begin
                $error("count_saturated: expected %0d, got %0d",
                       exp_res.saturated, saturated);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [ROW_WIDTH_W-1:0] cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [CELL_W-1:0]      s_tdata     = '0;   // [7:0] cell_char
    logic                   s_tlast     = 1'b0; // frame_last
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [19:0] window_count
    logic                   m_tuser;            // [0] count_saturated

    grid_tally   tally_sb;
    int unsigned sent_cells = 0;
    int unsigned grids_sent = 0;
    int          gap_pct    = 0;     // chance of a sender gap after each word
    bit          calm       = 1'b0;  // no idling on either side once set

    grid_3x3_pattern_counter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watch both channels at the edge; the values seen here are the ones the
    // DUT samples, since all drivers update through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tally_sb.note_cell(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                tally_sb.check_result(m_tdata[COUNT_OUT_W-1:0], m_tuser);
            end
        end
    end

    // Receiver: mix ready runs and stall bursts at random;
    // stay ready for good once the run turns calm.
    initial begin
        int run;
        wait (aresetn);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 20);
            end else begin
                m_tready <= 1'b0;
                run = $urandom_range(1, 12);
            end
            repeat (run) @(posedge aclk);
        end
    end

    // Give up well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one cell word and hold it until accepted; then maybe idle.
    task automatic push_cell(input logic [CELL_W-1:0] ch, input logic fin);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sent_cells++;
        if (fin) begin
            grids_sent++;
        end
        if (sent_cells >= CALM_AFTER) begin
            calm = 1'b1;
        end
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, let the monitor note the last accepted word, and wait
    // until every closed grid has reported.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tally_sb.pending() != 0) @(posedge aclk);
    endtask

    // Reprogram row_width on an idle block; let the line RAM write-back and
    // any result in flight settle first.
    task automatic write_width(input logic [ROW_WIDTH_W-1:0] w);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        tally_sb.set_width(w);
        cfg_wr_en <= 1'b0;
    endtask

    // Marks at the given density; the rest are dots, near misses of
    // '*' by one bit, or any byte.
    function automatic logic [CELL_W-1:0] pick_cell(input int density);
        logic [CELL_W-1:0] ch;
        if ($urandom_range(1, 100) <= density) begin
            return MARK_CHAR;
        end
        case ($urandom_range(0, 2))
            0: begin
                ch = DOT_CHAR;
            end
            1: begin
                ch = MARK_CHAR ^ (8'h01 << $urandom_range(0, 7));
            end
            default: begin
                ch = CELL_W'($urandom_range(0, 255));
            end
        endcase
        return ch;
    endfunction

    // Send n random cells; flag the last one when the grid is to close.
    task automatic send_cells(input int n, input int density, input bit close);
        for (int i = 0; i < n; i++) begin
            push_cell(pick_cell(density), close && (i == n - 1));
        end
    endtask

    // One 3x3 grid carrying a chosen shape plus random extra marks, often
    // followed by up to three cells of a fourth row.
    task automatic send_shape_grid();
        logic [8:0] shape;
        int         extra;
        shape = SHAPE_SET[$urandom_range(0, 7)];
        extra = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) begin
            push_cell(shape[i] ? MARK_CHAR : pick_cell(25), (extra == 0) && (i == 8));
        end
        if (extra != 0) begin
            send_cells(extra, 60, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int w;
        int rows;
        tally_sb = new();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no sender gaps.
        // Reset width is 1024: three cells hold no window; cover byte extremes.
        push_cell(8'h00, 1'b0);
        push_cell(8'hFF, 1'b0);
        push_cell(MARK_CHAR, 1'b1);
        // Width zero behaves as one column: a tall strip has no full window.
        write_width('0);
        push_cell(MARK_CHAR, 1'b0);
        push_cell(MARK_CHAR, 1'b0);
        push_cell(MARK_CHAR, 1'b1);
        // Fully marked 3x3 grid: exactly one matching window.
        write_width(11'd3);
        for (int i = 0; i < 9; i++) begin
            push_cell(MARK_CHAR, i == 8);
        end
        // Width beyond the line store clamps to its size.
        write_width(11'h7FF);
        push_cell(MARK_CHAR, 1'b0);
        push_cell(MARK_CHAR ^ 8'h01, 1'b1);
        // Shrink the width mid-grid while the column index sits past it.
        write_width(11'd5);
        repeat (4) push_cell(MARK_CHAR, 1'b0);
        write_width(11'd3);
        push_cell(MARK_CHAR, 1'b0);
        push_cell(MARK_CHAR, 1'b0);
        push_cell(MARK_CHAR, 1'b1);

        // Random part: mostly well-formed grids with random content.
        while (sent_cells < ITEM_TARGET || grids_sent < GRID_TARGET) begin
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            // Now and then hold the sender until every result is back.
            if ($urandom_range(0, 7) == 0) begin
                drain_results();
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4: begin
                    w    = $urandom_range(3, 8);
                    rows = $urandom_range(3, 6);
                    if ($urandom_range(0, 1) == 0 || tally_sb.width_reg != w) begin
                        write_width(ROW_WIDTH_W'(w));
                    end
                    // Allow a partial last row.
                    send_cells(w * rows - $urandom_range(0, w - 1),
                               $urandom_range(40, 95), 1'b1);
                end
                5, 6: begin
                    write_width(11'd3);
                    send_shape_grid();
                end
                7: begin
                    // Narrow grids: too few columns, or too few cells for a window.
                    if ($urandom_range(0, 1) == 0) begin
                        write_width(ROW_WIDTH_W'($urandom_range(0, 2)));
                        send_cells($urandom_range(1, 12), 90, 1'b1);
                    end else begin
                        write_width(ROW_WIDTH_W'($urandom_range(3, 6)));
                        send_cells($urandom_range(1, 5), 90, 1'b1);
                    end
                end
                8: begin
                    // Change the width partway through a grid.
                    w = $urandom_range(4, 9);
                    write_width(ROW_WIDTH_W'(w));
                    send_cells($urandom_range(1, 3 * w), 80, 1'b0);
                    write_width(ROW_WIDTH_W'($urandom_range(3, 9)));
                    send_cells($urandom_range(4, 24), 80, 1'b1);
                end
                default: begin
                    // Wide rows, below, at and beyond the line store size.
                    case ($urandom_range(0, 2))
                        0: begin
                            write_width(11'd1024);
                        end
                        1: begin
                            write_width(ROW_WIDTH_W'($urandom_range(1025, 2047)));
                        end
                        default: begin
                            write_width(ROW_WIDTH_W'($urandom_range(9, 1023)));
                        end
                    endcase
                    send_cells($urandom_range(1, 40), 80, 1'b1);
                end
            endcase
        end

        // Wait for every result, then let the pipeline settle.
        s_tvalid <= 1'b0;
        for (int i = 0; i < 5000 && tally_sb.pending() != 0; i++) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        if (tally_sb.pending() != 0) begin
            $error("%0d grid results never arrived", tally_sb.pending());
            tally_sb.fails++;
        end

        if (tally_sb.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* grid_3x3_pattern_counter.f */
+incdir+hdl
hdl/gpc_pkg.sv
hdl/gpc_line_ram.sv
hdl/grid_3x3_pattern_counter.sv
dv/tb_grid_3x3_pattern_counter.sv
